### hdl/rsa_pkg.sv
// shared types, constants and helpers for the rational sum accumulator
package rsa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
  localparam int SHIFT_WIDTH = $clog2(WIDE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [WIDE_WIDTH-1:0]  wide_t;
  typedef logic [SHIFT_WIDTH-1:0] shift_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_FOLD  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    logic   last;
    value_t num;
    value_t den;
  } entry_t;

  // start/done pair of a multi-cycle unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    wide_t result;
  } unit_rsp_t;

  function automatic value_t magnitude(input value_t v);
    return v[VALUE_WIDTH-1] ? value_t'(~v + value_t'(1)) : v;
  endfunction

endpackage

### hdl/rsa_front.sv
// front end: classifies items as set start or fold and queues them
module rsa_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  rsa_pkg::value_t numerator,
  input  rsa_pkg::value_t denominator,
  input  logic            first_item,
  input  logic            last_item,
  output logic            q_valid,
  output rsa_pkg::entry_t q_entry,
  input  logic            q_pop
);

  rsa_pkg::entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       set_open;
  logic       push;
  rsa_pkg::entry_t in_entry;

  assign ready   = (count != 2'd2);
  assign push    = valid && ready;
  assign q_valid = (count != 2'd0);
  assign q_entry = entries[rd_ptr];

  always_comb begin
    in_entry.kind = (first_item || !set_open) ? rsa_pkg::KIND_START : rsa_pkg::KIND_FOLD;
    in_entry.last = last_item;
    in_entry.num  = numerator;
    in_entry.den  = denominator;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      count    <= 2'd0;
      set_open <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr   <= ~wr_ptr;
        set_open <= !last_item;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### hdl/rsa_gcd.sv
// binary gcd unit, one step per cycle
module rsa_gcd (
  input  logic              clk,
  input  logic              rst,
  input  rsa_pkg::unit_req_t req,
  input  rsa_pkg::wide_t    op_a,
  input  rsa_pkg::wide_t    op_b,
  output rsa_pkg::unit_rsp_t rsp
);

  rsa_pkg::wide_t  a;
  rsa_pkg::wide_t  b;
  rsa_pkg::wide_t  res;
  rsa_pkg::shift_t k;
  logic            busy;
  logic            done;

  assign rsp.done   = done;
  assign rsp.result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= op_a;
        b    <= op_b;
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (a == '0) begin
          res  <= b << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (b == '0) begin
          res  <= a << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + rsa_pkg::shift_t'(1);
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= a - b;
        end else begin
          b <= b - a;
        end
      end
    end
  end

endmodule

### hdl/rsa_div.sv
// restoring divider, one quotient bit per cycle
module rsa_div (
  input  logic               clk,
  input  logic               rst,
  input  rsa_pkg::unit_req_t  req,
  input  rsa_pkg::wide_t     dividend,
  input  rsa_pkg::wide_t     divisor,
  output rsa_pkg::unit_rsp_t rsp
);

  rsa_pkg::wide_t  r;
  rsa_pkg::wide_t  qr;
  rsa_pkg::wide_t  dv;
  rsa_pkg::shift_t cnt;
  logic            busy;
  logic            done;
  logic [rsa_pkg::WIDE_WIDTH:0] rs;
  logic [rsa_pkg::WIDE_WIDTH:0] diff;

  assign rsp.done   = done;
  assign rsp.result = qr;

  assign rs   = {r, qr[rsa_pkg::WIDE_WIDTH-1]};
  assign diff = rs - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        r    <= '0;
        qr   <= dividend;
        dv   <= divisor;
        cnt  <= '1;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[rsa_pkg::WIDE_WIDTH]) begin
          r  <= diff[rsa_pkg::WIDE_WIDTH-1:0];
          qr <= {qr[rsa_pkg::WIDE_WIDTH-2:0], 1'b1};
        end else begin
          r  <= rs[rsa_pkg::WIDE_WIDTH-1:0];
          qr <= {qr[rsa_pkg::WIDE_WIDTH-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - rsa_pkg::shift_t'(1);
        end
      end
    end
  end

endmodule

### hdl/rsa_back.sv
// back end: fold sequencer, accumulator and result register
module rsa_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rsa_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output rsa_pkg::value_t sum_numerator,
  output rsa_pkg::value_t sum_denominator,
  output logic            overflow
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_GCD1   = 12'b000000000010,
    S_DIV_AR = 12'b000000000100,
    S_DIV_BR = 12'b000000001000,
    S_MUL_Q  = 12'b000000010000,
    S_MUL_PA = 12'b000000100000,
    S_MUL_PB = 12'b000001000000,
    S_ADD    = 12'b000010000000,
    S_GCD2   = 12'b000100000000,
    S_DIV_P  = 12'b001000000000,
    S_DIV_Q  = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  localparam int VW = rsa_pkg::VALUE_WIDTH;
  localparam int WW = rsa_pkg::WIDE_WIDTH;

  state_t state;
  logic   launched;

  rsa_pkg::value_t acc_n;
  rsa_pkg::value_t acc_d;
  logic            acc_ov;

  rsa_pkg::value_t anm, adm, bnm, bdm, ar, br;
  logic            sa, sb, neg, last;
  rsa_pkg::wide_t  gv, qv, pa, pb, pv;

  rsa_pkg::unit_req_t gcd_req, div_req;
  rsa_pkg::unit_rsp_t gcd_rsp, div_rsp;
  rsa_pkg::wide_t     gcd_a, gcd_b, div_n, div_d;
  rsa_pkg::value_t    mul_a, mul_b;
  rsa_pkg::wide_t     product;

  rsa_pkg::value_t m_an, m_ad, m_bn, m_bd;
  logic            pv_fits, qv_fits;

  assign q_pop = q_valid && (state == S_IDLE) && (!q_entry.last || !out_valid);

  assign m_an = rsa_pkg::magnitude(acc_n);
  assign m_ad = rsa_pkg::magnitude(acc_d);
  assign m_bn = rsa_pkg::magnitude(q_entry.num);
  assign m_bd = rsa_pkg::magnitude(q_entry.den);

  always_comb begin
    gcd_req.start = !launched && ((state == S_GCD1) || (state == S_GCD2));
    div_req.start = !launched && ((state == S_DIV_AR) || (state == S_DIV_BR) ||
                                  (state == S_DIV_P) || (state == S_DIV_Q));
    if (state == S_GCD1) begin
      gcd_a = WW'(adm);
      gcd_b = WW'(bdm);
    end else begin
      gcd_a = pv;
      gcd_b = qv;
    end
    case (state)
      S_DIV_AR: div_n = WW'(adm);
      S_DIV_BR: div_n = WW'(bdm);
      S_DIV_P:  div_n = pv;
      default:  div_n = qv;
    endcase
    div_d = gv;
    case (state)
      S_MUL_Q: begin
        mul_a = ar;
        mul_b = bdm;
      end
      S_MUL_PA: begin
        mul_a = anm;
        mul_b = br;
      end
      default: begin
        mul_a = bnm;
        mul_b = ar;
      end
    endcase
  end

  assign product = WW'(mul_a) * WW'(mul_b);

  assign qv_fits = (qv[WW-1:VW-1] == '0);
  assign pv_fits = (pv[WW-1:VW] == '0) &&
                   (!pv[VW-1] || (neg && (pv[VW-2:0] == '0)));

  rsa_gcd u_gcd (
    .clk  (clk),
    .rst  (rst),
    .req  (gcd_req),
    .op_a (gcd_a),
    .op_b (gcd_b),
    .rsp  (gcd_rsp)
  );

  rsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_n),
    .divisor  (div_d),
    .rsp      (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      acc_n     <= '0;
      acc_d     <= rsa_pkg::value_t'(1);
      acc_ov    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (gcd_req.start || div_req.start) begin
        launched <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            last <= q_entry.last;
            if (q_entry.kind == rsa_pkg::KIND_START) begin
              acc_n  <= q_entry.num;
              acc_d  <= q_entry.den;
              acc_ov <= 1'b0;
              if (q_entry.last) begin
                out_valid       <= 1'b1;
                sum_numerator   <= q_entry.num;
                sum_denominator <= q_entry.den;
                overflow        <= 1'b0;
              end
            end else begin
              anm <= m_an;
              adm <= m_ad;
              bnm <= m_bn;
              bdm <= m_bd;
              if (m_ad == '0 && m_bd == '0) begin
                // both denominators zero: plain numerator sum over one
                pa    <= WW'(m_an);
                pb    <= WW'(m_bn);
                sa    <= acc_n[VW-1];
                sb    <= q_entry.num[VW-1];
                qv    <= WW'(1);
                state <= S_ADD;
              end else if (m_ad == '0 || m_bd == '0) begin
                pa    <= '0;
                pb    <= '0;
                sa    <= 1'b0;
                sb    <= 1'b0;
                qv    <= WW'(1);
                state <= S_ADD;
              end else begin
                sa    <= acc_n[VW-1] ^ acc_d[VW-1];
                sb    <= q_entry.num[VW-1] ^ q_entry.den[VW-1];
                state <= S_GCD1;
              end
            end
          end
        end
        S_GCD1: begin
          if (gcd_rsp.done) begin
            gv       <= gcd_rsp.result;
            launched <= 1'b0;
            state    <= S_DIV_AR;
          end
        end
        S_DIV_AR: begin
          if (div_rsp.done) begin
            ar       <= div_rsp.result[VW-1:0];
            launched <= 1'b0;
            state    <= S_DIV_BR;
          end
        end
        S_DIV_BR: begin
          if (div_rsp.done) begin
            br       <= div_rsp.result[VW-1:0];
            launched <= 1'b0;
            state    <= S_MUL_Q;
          end
        end
        S_MUL_Q: begin
          qv    <= product;
          state <= S_MUL_PA;
        end
        S_MUL_PA: begin
          pa    <= product;
          state <= S_MUL_PB;
        end
        S_MUL_PB: begin
          pb    <= product;
          state <= S_ADD;
        end
        S_ADD: begin
          if (sa == sb) begin
            pv  <= pa + pb;
            neg <= sa && ((pa + pb) != '0);
          end else if (pa >= pb) begin
            pv  <= pa - pb;
            neg <= sa && (pa != pb);
          end else begin
            pv  <= pb - pa;
            neg <= sb;
          end
          state <= S_GCD2;
        end
        S_GCD2: begin
          if (gcd_rsp.done) begin
            gv       <= gcd_rsp.result;
            launched <= 1'b0;
            state    <= S_DIV_P;
          end
        end
        S_DIV_P: begin
          if (div_rsp.done) begin
            pv       <= div_rsp.result;
            launched <= 1'b0;
            state    <= S_DIV_Q;
          end
        end
        S_DIV_Q: begin
          if (div_rsp.done) begin
            qv       <= div_rsp.result;
            launched <= 1'b0;
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          acc_n  <= neg ? rsa_pkg::value_t'(~pv[VW-1:0] + 1'b1) : pv[VW-1:0];
          acc_d  <= qv[VW-1:0];
          acc_ov <= acc_ov || !pv_fits || !qv_fits;
          if (last) begin
            out_valid       <= 1'b1;
            sum_numerator   <= neg ? rsa_pkg::value_t'(~pv[VW-1:0] + 1'b1) : pv[VW-1:0];
            sum_denominator <= qv[VW-1:0];
            overflow        <= acc_ov || !pv_fits || !qv_fits;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/rational_sum_accumulator_top.sv
// top level of the rational sum accumulator
//
//  channel  handshake          payload
//  input    valid / ready      numerator, denominator, first_item, last_item
//  output   out_valid / out_ready  sum_numerator, sum_denominator, overflow
//
// a set start is taken by the back end straight from idle; the time of a fold is
// set by the shared 64-bit divider (two divisions to reduce the sum, two more
// for the lcm when no denominator is zero) and the binary gcd at one step per
// cycle, run on the denominators (when neither is zero) and on the reduced sum
// two items queue between front and back, so input is taken while a fold runs
// a result waits in the output register and only a set end stalls behind it
// reset is synchronous and leaves the accumulator at 0/1 with no open set
module rational_sum_accumulator_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  rsa_pkg::value_t numerator,
  input  rsa_pkg::value_t denominator,
  input  logic            first_item,
  input  logic            last_item,
  output logic            out_valid,
  input  logic            out_ready,
  output rsa_pkg::value_t sum_numerator,
  output rsa_pkg::value_t sum_denominator,
  output logic            overflow
);

  logic            q_valid;
  logic            q_pop;
  rsa_pkg::entry_t q_entry;

  rsa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (valid),
    .ready       (ready),
    .numerator   (numerator),
    .denominator (denominator),
    .first_item  (first_item),
    .last_item   (last_item),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  rsa_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sum_numerator   (sum_numerator),
    .sum_denominator (sum_denominator),
    .overflow        (overflow)
  );

endmodule

### bench/tb_rational_sum_accumulator_top.sv
// testbench for the rational sum accumulator: fraction set sums checked against a local predictor
module tb_rational_sum_accumulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 600;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct {
    rsa_pkg::value_t num;
    rsa_pkg::value_t den;
    logic            first;
    logic            last;
  } frac_item_t;

  typedef struct {
    rsa_pkg::value_t num;
    rsa_pkg::value_t den;
    logic            ovf;
  } frac_sum_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            valid = 1'b0;
  logic            ready;
  rsa_pkg::value_t numerator = '0;
  rsa_pkg::value_t denominator = '0;
  logic            first_item = 1'b0;
  logic            last_item = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  rsa_pkg::value_t sum_numerator;
  rsa_pkg::value_t sum_denominator;
  logic            overflow;

  rational_sum_accumulator_top uut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .numerator(numerator), .denominator(denominator),
    .first_item(first_item), .last_item(last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .sum_numerator(sum_numerator), .sum_denominator(sum_denominator),
    .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frac_item_t pending_items[$];
  frac_sum_t  expected_sums[$];
  int     errors = 0;
  int     items_sent = 0;
  int     sums_checked = 0;
  int     ovf_seen = 0;
  int     idle_cycles = 0;
  int     cycle_count = 0;
  bit     holding = 0;
  int     burst_left = 4;
  int     gap_left = 0;

  // predictor state
  rsa_pkg::value_t run_num = '0;
  rsa_pkg::value_t run_den = 32'd1;
  logic            run_ovf = 1'b0;
  int              run_count = 0;

  function automatic logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
    logic [127:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [127:0] mag(rsa_pkg::value_t v);
    return {96'b0, v[rsa_pkg::VALUE_WIDTH-1] ? rsa_pkg::value_t'(~v + 1'b1) : v};
  endfunction

  // signed sum of two magnitudes, returns magnitude and sign
  function automatic logic [127:0] add_signed(logic sa, logic [127:0] a, logic sb,
                                              logic [127:0] b, output logic neg);
    logic [127:0] r;
    if (sa == sb) begin
      r = a + b;
      neg = sa;
    end else if (a >= b) begin
      r = a - b;
      neg = sa;
    end else begin
      r = b - a;
      neg = sb;
    end
    if (r == 0) neg = 1'b0;
    return r;
  endfunction

  task automatic fold_fraction(rsa_pkg::value_t bn, rsa_pkg::value_t bd);
    logic [127:0] anm, adm, bnm, bdm, p, q, g, ar, br, c;
    logic neg;
    anm = mag(run_num);
    adm = mag(run_den);
    bnm = mag(bn);
    bdm = mag(bd);
    neg = 1'b0;
    if (adm == 0 && bdm == 0) begin
      p = add_signed(run_num[31], anm, bn[31], bnm, neg);
      q = 1;
    end else if (adm == 0 || bdm == 0) begin
      p = 0;
      q = 1;
    end else begin
      g = gcd128(adm, bdm);
      ar = adm / g;
      br = bdm / g;
      q = ar * bdm;
      p = add_signed(run_num[31] != run_den[31], anm * br,
                     bn[31] != bd[31], bnm * ar, neg);
    end
    c = gcd128(p, q);
    p = p / c;
    q = q / c;
    if (q >= 128'h8000_0000) run_ovf = 1'b1;
    if (!(p < 128'h8000_0000 || (neg && p == 128'h8000_0000))) run_ovf = 1'b1;
    run_num = neg ? rsa_pkg::value_t'(~p[31:0] + 1'b1) : p[31:0];
    run_den = q[31:0];
  endtask

  task automatic predict_sum(frac_item_t it);
    frac_sum_t s;
    if (it.first || run_count == 0) begin
      run_num = it.num;
      run_den = it.den;
      run_ovf = 1'b0;
      run_count = 1;
    end else begin
      fold_fraction(it.num, it.den);
      run_count = 2;
    end
    if (it.last) begin
      s.num = run_num;
      s.den = run_den;
      s.ovf = run_ovf;
      expected_sums.push_back(s);
      run_count = 0;
    end
  endtask

  task automatic report_mismatch(string what, rsa_pkg::value_t got, rsa_pkg::value_t want);
    $display("mismatch on %s at sum %0d: got %h expected %h", what, sums_checked, got, want);
    errors++;
  endtask

  // sender: bursts and gaps; valid held until accept
  always @(negedge clk) begin
    if (!rst && !holding) begin
      if (gap_left > 0) begin
        gap_left--;
        valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        numerator   <= pending_items[0].num;
        denominator <= pending_items[0].den;
        first_item  <= pending_items[0].first;
        last_item   <= pending_items[0].last;
        valid <= 1'b1;
        holding = 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, rotating through three modes
  always @(negedge clk) begin
    case ((cycle_count / 3000) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= (cycle_count % 17) < 6;
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    frac_item_t it;
    frac_sum_t  want;
    cycle_count++;
    if (!rst) begin
      if (valid && ready) begin
        it.num = numerator;
        it.den = denominator;
        it.first = first_item;
        it.last = last_item;
        predict_sum(it);
        void'(pending_items.pop_front());
        holding = 0;
        items_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $display("unexpected sum %h/%h", sum_numerator, sum_denominator);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (sum_numerator !== want.num) report_mismatch("numerator", sum_numerator, want.num);
          if (sum_denominator !== want.den)
            report_mismatch("denominator", sum_denominator, want.den);
          if (overflow !== want.ovf)
            report_mismatch("overflow", rsa_pkg::value_t'(overflow),
                            rsa_pkg::value_t'(want.ovf));
          if (want.ovf) ovf_seen++;
        end
        sums_checked++;
      end
      if ((valid && ready) || (out_valid && out_ready)) idle_cycles = 0;
      else if (expected_sums.size() > 0 || pending_items.size() > 0) idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic rsa_pkg::value_t rand_value();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 4))
           0: return 32'd0;
           1: return 32'd1;
           2: return 32'hffff_ffff;
           3: return 32'h8000_0000;
           default: return 32'h7fff_ffff;
         endcase
      1, 2, 3, 4: return rsa_pkg::value_t'($urandom_range(0, 40) - 20);
      5, 6, 7: return rsa_pkg::value_t'($signed(16'($urandom)));
      default: return rsa_pkg::value_t'($urandom);
    endcase
  endfunction

  function automatic rsa_pkg::value_t rand_den();
    rsa_pkg::value_t d;
    d = rand_value();
    // zero denominators only now and then
    if (d == 0 && $urandom_range(0, 3) != 0) d = 32'd1;
    return d;
  endfunction

  task automatic add_item(rsa_pkg::value_t n, rsa_pkg::value_t d, logic f, logic l);
    frac_item_t it;
    it.num = n;
    it.den = d;
    it.first = f;
    it.last = l;
    pending_items.push_back(it);
  endtask

  initial begin
    int len;
    int total;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single item sets, passed through as is
    add_item(32'h8000_0000, 32'd0, 1, 1);
    add_item(32'h7fff_ffff, 32'hffff_fffe, 1, 1);
    // zero sum
    add_item(32'd1, 32'd2, 1, 0);
    add_item(32'hffff_ffff, 32'd2, 0, 1);
    // both denominators zero
    add_item(32'd5, 32'd0, 1, 0);
    add_item(32'hffff_fff9, 32'd0, 0, 1);
    // one denominator zero
    add_item(32'd3, 32'd4, 1, 0);
    add_item(32'd9, 32'd0, 0, 1);
    // overflow by numerator and by denominator
    add_item(32'h7fff_ffff, 32'd1, 1, 0);
    add_item(32'h7fff_ffff, 32'd1, 0, 1);
    add_item(32'd1, 32'h7fff_ffff, 1, 0);
    add_item(32'd1, 32'h7fff_fffe, 0, 0);
    add_item(32'd0, 32'd1, 0, 1);
    // most negative values
    add_item(32'h8000_0000, 32'h8000_0000, 1, 0);
    add_item(32'h8000_0000, 32'hffff_ffff, 0, 1);
    // no open set, first not marked
    add_item(32'd7, 32'd3, 0, 0);
    add_item(32'd2, 32'hffff_fffd, 0, 1);
    // restart inside an open set
    add_item(32'd11, 32'd13, 1, 0);
    add_item(32'd1, 32'd6, 1, 0);
    add_item(32'd1, 32'd4, 0, 1);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
      for (int i = 0; i < len; i++) begin
        logic f, l;
        f = (i == 0);
        l = (i == len - 1);
        // noise: broken sets
        if ($urandom_range(0, 19) == 0) f = ~f;
        if ($urandom_range(0, 29) == 0) l = 1'b0;
        add_item(rand_value(), rand_den(), f, l);
        total++;
      end
    end
    add_item(32'd1, 32'd1, 1, 1);

    wait (pending_items.size() == 0 && !holding);
    wait (expected_sums.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d fraction items, checked %0d sums (%0d with overflow)",
             items_sent, sums_checked, ovf_seen);
    if (expected_sums.size() > 0) errors++;
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d errors", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
